FILE: rtl/core/dctr_pkg.sv
// Package for the dirty character-cell text refresh block.
// Holds item structs, command/status structs, codes and layout constants.
// No dependencies; used by every file under rtl/core.
package dctr_pkg;

  localparam int FIELD_COUNT = 6;
  localparam int FIELD_CHARS = 11;
  localparam int CELL_TOTAL  = FIELD_COUNT * FIELD_CHARS;
  localparam int ADDR_W      = $clog2(CELL_TOTAL);

  // Operation codes
  localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
  localparam logic [1:0] OP_SET_COLOR  = 2'd1;
  localparam logic [1:0] OP_REFRESH    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DISPLAY_ENABLED = 2'd0;
  localparam logic [1:0] CFG_PANEL_COLOR     = 2'd1;
  localparam logic [1:0] CFG_CHAR_SCALE      = 2'd2;

  // Reset values
  localparam logic [15:0] RESET_FG    = 16'd59326;
  localparam logic [15:0] RESET_PANEL = 16'd2309;
  localparam logic [2:0]  RESET_SCALE = 3'd2;
  localparam logic [7:0]  CHAR_SPACE  = 8'h20;

  // Panel layout
  localparam logic [9:0] X_BASE_EVEN = 10'd16;
  localparam logic [9:0] X_BASE_ODD  = 10'd170;
  localparam logic [7:0] Y_BASE      = 8'd66;
  localparam logic [7:0] Y_STEP      = 8'd62;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  field_sel;
    logic [3:0]  char_pos;
    logic [7:0]  char_code;
    logic [15:0] color;
    logic        draw_ok;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  draw_x;
    logic [7:0]  draw_y;
    logic [7:0]  draw_char;
    logic [15:0] draw_color;
    logic [15:0] draw_background;
    logic [2:0]  draw_scale;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_char;
    logic set_color;
    logic start;
    logic run;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enabled;
    logic hit;
    logic done;
    logic out_free;
  } dp_stat_t;

  // Pixel row of a field: fields are stacked in pairs.
  function automatic logic [7:0] field_y(input logic [2:0] f);
    logic [7:0] row;
    row = 8'(f >> 1);
    return 8'(Y_BASE + row * Y_STEP);
  endfunction

  function automatic logic [9:0] field_x(input logic [2:0] f);
    return f[0] ? X_BASE_ODD : X_BASE_EVEN;
  endfunction

endpackage

FILE: rtl/core/dctr_ctrl.sv
// Controller for the dirty character-cell text refresh block.
// Decodes accepted items into datapath commands and sequences the refresh scan.
// Depends on dctr_pkg.
module dctr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  input  dctr_pkg::dp_stat_t  stat,
  output dctr_pkg::dp_cmd_t   cmd
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            dctr_pkg::OP_WRITE_CHAR: cmd.wr_char = 1'b1;
            dctr_pkg::OP_SET_COLOR:  cmd.set_color = 1'b1;
            dctr_pkg::OP_REFRESH: begin
              if (stat.enabled) begin
                cmd.start = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          // hold the found cell until the output register is free
          if (stat.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (stat.done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.run = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/dctr_datapath.sv
// Datapath for the dirty character-cell text refresh block.
// Text stores, field colours, configuration, scan pipeline and output register.
// Depends on dctr_pkg.
module dctr_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  dctr_pkg::in_item_t  in_data,
  input  dctr_pkg::dp_cmd_t   cmd,
  output dctr_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output dctr_pkg::out_item_t out_data
);

  localparam int AW = dctr_pkg::ADDR_W;
  localparam int CT = dctr_pkg::CELL_TOTAL;

  // Configuration
  logic        display_enabled_r;
  logic [15:0] panel_color_r;
  logic [2:0]  char_scale_r;

  // Stores; valid bits give the reset contents of unwritten cells
  logic [7:0]  wanted_mem [CT];
  logic [7:0]  shown_mem  [CT];
  logic [CT-1:0] wanted_vld_r;
  logic [CT-1:0] shown_vld_r;
  logic [15:0] field_color_r [dctr_pkg::FIELD_COUNT];

  // Scan issue stage
  logic [2:0]    iss_f_r;
  logic [3:0]    iss_p_r;
  logic [AW-1:0] iss_a_r;
  logic          iss_end_r;

  // Scan compare stage
  logic [2:0]    cmp_f_r;
  logic [3:0]    cmp_p_r;
  logic [AW-1:0] cmp_a_r;
  logic          cmp_vld_r;
  logic [7:0]    wanted_rd_r;
  logic [7:0]    shown_rd_r;
  logic          wanted_rd_vld_r;
  logic          shown_rd_vld_r;

  logic          ok_r;
  logic          out_valid_r;
  dctr_pkg::out_item_t out_data_r;

  logic [7:0]    wanted_val;
  logic [7:0]    shown_val;
  logic          fld_ok;
  logic          pos_ok;
  logic [AW-1:0] wr_addr;
  logic [2:0]    col_idx;
  logic [15:0]   col_rd;
  logic          col_change;
  logic [6:0]    pitch_prod;
  logic [9:0]    pitch_x;
  logic [9:0]    draw_x;

  assign wanted_val = wanted_rd_vld_r ? wanted_rd_r : dctr_pkg::CHAR_SPACE;
  assign shown_val  = shown_rd_vld_r  ? shown_rd_r  : 8'd0;

  assign fld_ok  = (32'(in_data.field_sel) < dctr_pkg::FIELD_COUNT);
  assign pos_ok  = (32'(in_data.char_pos) < dctr_pkg::FIELD_CHARS);
  assign wr_addr = AW'(AW'(in_data.field_sel) * AW'(dctr_pkg::FIELD_CHARS))
                   + AW'(in_data.char_pos);

  // One colour read port, shared by the set-colour compare and the draw
  assign col_idx    = cmd.set_color ? in_data.field_sel : cmp_f_r;
  assign col_rd     = field_color_r[col_idx];
  assign col_change = fld_ok && (col_rd != in_data.color);

  // x = base + pos * 6 * scale
  assign pitch_prod = 7'(cmp_p_r) * 7'(char_scale_r);
  assign pitch_x    = (10'(pitch_prod) << 2) + (10'(pitch_prod) << 1);
  assign draw_x     = dctr_pkg::field_x(cmp_f_r) + pitch_x;

  assign stat.enabled  = display_enabled_r;
  assign stat.hit      = cmp_vld_r && (wanted_val != shown_val);
  assign stat.done     = iss_end_r && !cmp_vld_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration and colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_enabled_r <= 1'b0;
      panel_color_r     <= dctr_pkg::RESET_PANEL;
      char_scale_r      <= dctr_pkg::RESET_SCALE;
      for (int i = 0; i < dctr_pkg::FIELD_COUNT; i++) begin
        field_color_r[i] <= dctr_pkg::RESET_FG;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dctr_pkg::CFG_DISPLAY_ENABLED: display_enabled_r <= cfg_wdata[0];
          dctr_pkg::CFG_PANEL_COLOR:     panel_color_r     <= cfg_wdata;
          dctr_pkg::CFG_CHAR_SCALE:      char_scale_r      <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (cmd.set_color && col_change) begin
        field_color_r[col_idx] <= in_data.color;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_vld_r <= '0;
      shown_vld_r  <= '0;
    end else begin
      if (cmd.wr_char && fld_ok && pos_ok) begin
        wanted_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.emit && ok_r) begin
        shown_vld_r[cmp_a_r] <= 1'b1;
      end
      if (cmd.set_color && col_change) begin
        for (int i = 0; i < CT; i++) begin
          if ((i / dctr_pkg::FIELD_CHARS) == int'(in_data.field_sel)) begin
            shown_vld_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.wr_char && fld_ok && pos_ok) begin
      wanted_mem[wr_addr] <= in_data.char_code;
    end
    if (cmd.emit && ok_r) begin
      shown_mem[cmp_a_r] <= wanted_val;
    end
    if (cmd.run && !iss_end_r) begin
      wanted_rd_r     <= wanted_mem[iss_a_r];
      shown_rd_r      <= shown_mem[iss_a_r];
      wanted_rd_vld_r <= wanted_vld_r[iss_a_r];
      shown_rd_vld_r  <= shown_vld_r[iss_a_r];
      cmp_f_r         <= iss_f_r;
      cmp_p_r         <= iss_p_r;
      cmp_a_r         <= iss_a_r;
    end
    if (cmd.start) begin
      ok_r <= in_data.draw_ok;
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_f_r   <= '0;
      iss_p_r   <= '0;
      iss_a_r   <= '0;
      iss_end_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.start) begin
      iss_f_r   <= '0;
      iss_p_r   <= '0;
      iss_a_r   <= '0;
      iss_end_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.run) begin
      cmp_vld_r <= !iss_end_r;
      if (!iss_end_r) begin
        if (32'(iss_a_r) == CT - 1) begin
          iss_end_r <= 1'b1;
        end else begin
          iss_a_r <= iss_a_r + 1'b1;
          if (32'(iss_p_r) == dctr_pkg::FIELD_CHARS - 1) begin
            iss_p_r <= '0;
            iss_f_r <= iss_f_r + 1'b1;
          end else begin
            iss_p_r <= iss_p_r + 1'b1;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.draw_x          <= draw_x;
      out_data_r.draw_y          <= dctr_pkg::field_y(cmp_f_r);
      out_data_r.draw_char       <= wanted_val;
      out_data_r.draw_color      <= col_rd;
      out_data_r.draw_background <= panel_color_r;
      out_data_r.draw_scale      <= char_scale_r;
    end
  end

endmodule

FILE: rtl/core/dirty_cell_text_refresh.sv
// Dirty character-cell text refresh: top level joining controller and datapath.
// Depends on dctr_pkg, dctr_ctrl and dctr_datapath.
//
// The block keeps wanted and shown text for six fields of eleven cells and a
// foreground colour per field. Write-char and set-colour items are accepted
// back to back. A refresh item (acted on only while display_enabled is set)
// runs a scan that reads one cell per cycle from the two text stores through
// a one-deep read pipeline, in field then position order, and stops at the
// first cell whose shown and wanted characters differ. A found cell waits
// until the output register is free; a scan of a clean display ends after
// the last cell. The scan rate is set by the single read port of each text
// store. The found cell is loaded into an output register; while a draw
// command waits there, further items are still accepted, and a later refresh
// only holds once its own cell is found. While a refresh is in progress
// in_stall stays high. Configuration writes take effect at once and should
// only be issued while the block is idle.
module dirty_cell_text_refresh (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  dctr_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output dctr_pkg::out_item_t out_data
);

  dctr_pkg::dp_cmd_t  cmd;
  dctr_pkg::dp_stat_t stat;

  // Decode items and sequence the scan
  dctr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, scan pipeline and output register
  dctr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A draw command is only loaded for a real dirty cell
  a_emit_on_hit : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.hit)
    else $error("draw command issued without a dirty cell");

  // Never overwrite a draw command that has not been transferred
  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten before transfer");

  // Input must be held off once a refresh has been started
  a_busy_after_start : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> in_stall)
    else $error("input accepted right after a refresh started");

  // Scan advances only while the input side is stalled
  a_run_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> in_stall)
    else $error("scan running while input side is open");

endmodule
